// ----- rtl/arztm_pkg.sv -----
// Rotozoom texture mapper: shared constants, types and the sine table.
// No dependencies; every other file imports this package.
package arztm_pkg;

	// screen and texture geometry
	localparam int SCREEN_W = 320;
	localparam int SCREEN_H = 200;
	localparam int TEX_W    = 256;
	localparam int TEX_H    = 64;
	localparam int HALF_W   = SCREEN_W / 2;
	localparam int HALF_H   = SCREEN_H / 2;

	// field widths
	localparam int KIND_W  = 2;
	localparam int ADDR_W  = 14;
	localparam int COLOR_W = 8;
	localparam int FRAME_W = 32;
	localparam int X_W     = 9;
	localparam int Y_W     = 8;
	localparam int U_W     = 16;  // 8.8
	localparam int V_W     = 14;  // 6.8
	localparam int D_W     = 14;  // signed deltas
	localparam int SHIFT_W = 5;
	localparam int PHASE_W = 8;
	localparam int SIN_W   = 10;  // signed, +-256
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	// zoom = ZOOM_BASE + floor(ZOOM_AMP * sin / 256)
	localparam int ZOOM_BASE = 2080;
	localparam int ZOOM_AMP  = 2016;
	localparam int ZPROD_W   = 22;
	localparam int DPROD_W   = 24;

	localparam logic [U_W-1:0] CENTER_U = U_W'((TEX_W / 2) * 256);
	localparam logic [V_W-1:0] CENTER_V = V_W'((TEX_H / 2) * 256);

	// word queue between front and back
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCOUNT_W = $clog2(QDEPTH + 1);

	// input kind codes
	localparam logic [KIND_W-1:0] KIND_TEXEL  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FRAME  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PIXEL  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KEY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIFT = 2'd3;

	localparam logic [COLOR_W-1:0] KEY_RST   = 8'd15;
	localparam logic [PHASE_W-1:0] ROT_RST   = 8'd1;
	localparam logic [PHASE_W-1:0] PAN_RST   = 8'd2;
	localparam logic [SHIFT_W-1:0] DRIFT_RST = 5'd5;

	typedef enum logic [1:0] {
		OP_TEXEL = 2'd0,
		OP_FRAME = 2'd1,
		OP_PIXEL = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] value;
		logic [FRAME_W-1:0] frame;
		logic [COLOR_W-1:0] bg;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic [COLOR_W-1:0] transparent_key;
		logic [PHASE_W-1:0] rotation_step;
		logic [PHASE_W-1:0] pan_step;
		logic [SHIFT_W-1:0] zoom_drift_shift;
	} cfg_t;

	typedef struct packed {
		logic signed [D_W-1:0] du_col;
		logic signed [D_W-1:0] dv_col;
		logic signed [D_W-1:0] du_row;
		logic signed [D_W-1:0] dv_row;
		logic [U_W-1:0]        u0;
		logic [V_W-1:0]        v0;
	} geom_t;

	typedef struct packed {
		logic               start;
		logic [FRAME_W-1:0] frame;
	} setup_req_t;

	typedef struct packed {
		logic  busy;
		logic  done;
		geom_t geom;
	} setup_rsp_t;

	localparam logic [8:0] QUARTER_SINE [0:64] = '{
		9'd0,   9'd6,   9'd13,  9'd19,  9'd25,  9'd31,  9'd38,  9'd44,
		9'd50,  9'd56,  9'd62,  9'd68,  9'd74,  9'd80,  9'd86,  9'd92,
		9'd98,  9'd104, 9'd109, 9'd115, 9'd121, 9'd126, 9'd132, 9'd137,
		9'd142, 9'd147, 9'd152, 9'd157, 9'd162, 9'd167, 9'd172, 9'd177,
		9'd181, 9'd185, 9'd190, 9'd194, 9'd198, 9'd202, 9'd206, 9'd209,
		9'd213, 9'd216, 9'd220, 9'd223, 9'd226, 9'd229, 9'd231, 9'd234,
		9'd237, 9'd239, 9'd241, 9'd243, 9'd245, 9'd247, 9'd248, 9'd250,
		9'd251, 9'd252, 9'd253, 9'd254, 9'd255, 9'd255, 9'd256, 9'd256,
		9'd256
	};

	// full-turn sine over 256 phases, +-256 = +-1.0
	function automatic logic signed [SIN_W-1:0] sine_rom(input logic [PHASE_W-1:0] idx);
		logic [6:0] h;
		logic [6:0] mi;
		logic [8:0] m;
		h  = idx[6:0];
		mi = (h <= 7'd64) ? h : 7'(8'd128 - {1'b0, h});
		m  = QUARTER_SINE[mi];
		return idx[7] ? -$signed({1'b0, m}) : $signed({1'b0, m});
	endfunction

endpackage

// ----- rtl/arztm_if.sv -----
// Rotozoom texture mapper: valid/ready channel interfaces for input and result words.
// Depends on arztm_pkg for field widths.
interface arztm_in_if import arztm_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [ADDR_W-1:0]   texel_address;
	logic [COLOR_W-1:0]  texel_value;
	logic [FRAME_W-1:0]  frame_number;
	logic [COLOR_W-1:0]  background;

	modport source (output valid, kind, texel_address, texel_value, frame_number,
		background, input ready);
	modport sink (input valid, kind, texel_address, texel_value, frame_number,
		background, output ready);
endinterface

interface arztm_out_if import arztm_pkg::*; ;
	logic                valid;
	logic                ready;
	logic [COLOR_W-1:0]  colour;
	logic [X_W-1:0]      pixel_x;
	logic [Y_W-1:0]      pixel_y;
	logic                frame_last;

	modport source (output valid, colour, pixel_x, pixel_y, frame_last, input ready);
	modport sink (input valid, colour, pixel_x, pixel_y, frame_last, output ready);
endinterface

// ----- rtl/arztm_front.sv -----
// Rotozoom texture mapper front: accepts input words, classifies them, queues them.
// Depends on arztm_pkg and arztm_in_if.
module arztm_front import arztm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	arztm_in_if.sink   feed,
	output q_head_t    head,
	input  logic       pop
);

	item_t                slot_q [QDEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QCOUNT_W-1:0]  count_q;
	logic                 keep;
	logic                 push;
	op_t                  op;

	// kind 3 is taken and dropped
	always_comb begin
		keep = 1'b1;
		op   = OP_TEXEL;
		unique case (feed.kind)
			KIND_TEXEL: op = OP_TEXEL;
			KIND_FRAME: op = OP_FRAME;
			KIND_PIXEL: op = OP_PIXEL;
			default:    keep = 1'b0;
		endcase
	end

	assign feed.ready = (count_q != QCOUNT_W'(QDEPTH));
	assign push       = feed.valid && feed.ready && keep;
	assign head.valid = (count_q != '0);
	assign head.item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{op: op, addr: feed.texel_address, value: feed.texel_value,
				frame: feed.frame_number, bg: feed.background};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/arztm_setup.sv -----
// Rotozoom texture mapper frame setup: sequencer deriving deltas and origin per frame.
// Depends on arztm_pkg (sine table, geometry constants).
module arztm_setup import arztm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  setup_req_t req,
	output setup_rsp_t rsp
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_TRIG   = 5'b00010,
		S_ZOOM   = 5'b00100,
		S_DELTA  = 5'b01000,
		S_ORIGIN = 5'b10000
	} setup_state_t;

	setup_state_t state_q;
	logic         done_q;

	logic [PHASE_W-1:0]          ang_q, zph_q, pan_q;
	logic signed [SIN_W-1:0]     cos_q, sin_q, nsin_q;
	logic signed [ZPROD_W-1:0]   zprod_q;
	logic [U_W-1:0]              cu_q;
	logic [V_W-1:0]              cv_q;
	logic signed [D_W-1:0]       z_q;
	logic signed [D_W-1:0]       du_col_q, dv_col_q, du_row_q, dv_row_q;
	logic [U_W-1:0]              u0_q;
	logic [V_W-1:0]              v0_q;

	// combinational helpers, one stage each
	logic signed [SIN_W-1:0]     s_ang, s_cos, s_zph, s_pan, s_panc;
	logic signed [ZPROD_W-1:0]   szph_x;
	logic signed [U_W-1:0]       span_x;
	logic signed [V_W-1:0]       spanc_x;
	logic signed [D_W-1:0]       zsh;
	logic signed [DPROD_W-1:0]   cos_x, sin_x, nsin_x, z_x, p_cz, p_sz, p_nsz;
	logic signed [U_W-1:0]       du_col_x, du_row_x;
	logic signed [V_W-1:0]       dv_col_x, dv_row_x;
	logic [U_W-1:0]              u_off_c, u_off_r;
	logic [V_W-1:0]              v_off_c, v_off_r;

	always_comb begin
		s_ang   = sine_rom(ang_q);
		s_cos   = sine_rom(ang_q + PHASE_W'(64));
		s_zph   = sine_rom(zph_q);
		s_pan   = sine_rom(pan_q);
		s_panc  = sine_rom(pan_q + PHASE_W'(64));
		szph_x  = ZPROD_W'(s_zph);
		span_x  = U_W'(s_pan);
		spanc_x = V_W'(s_panc);

		zsh = D_W'(zprod_q >>> 8);

		cos_x  = DPROD_W'(cos_q);
		sin_x  = DPROD_W'(sin_q);
		nsin_x = DPROD_W'(nsin_q);
		z_x    = DPROD_W'(z_q);
		p_cz   = cos_x * z_x;
		p_sz   = sin_x * z_x;
		p_nsz  = nsin_x * z_x;

		// origin arithmetic wraps like the coordinates
		du_col_x = U_W'(du_col_q);
		du_row_x = U_W'(du_row_q);
		dv_col_x = V_W'(dv_col_q);
		dv_row_x = V_W'(dv_row_q);
		u_off_c  = U_W'(du_col_x * U_W'(HALF_W));
		u_off_r  = U_W'(du_row_x * U_W'(HALF_H));
		v_off_c  = V_W'(dv_col_x * V_W'(HALF_W));
		v_off_r  = V_W'(dv_row_x * V_W'(HALF_H));
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ang_q <= PHASE_W'(req.frame[PHASE_W-1:0] * cfg.rotation_step);
				pan_q <= PHASE_W'(req.frame[PHASE_W-1:0] * cfg.pan_step);
				zph_q <= req.frame[PHASE_W-1:0]
					+ PHASE_W'(req.frame >> cfg.zoom_drift_shift);
			end
			S_TRIG: begin
				cos_q   <= s_cos;
				sin_q   <= s_ang;
				nsin_q  <= -s_ang;
				zprod_q <= szph_x * ZPROD_W'(ZOOM_AMP);
				cu_q    <= CENTER_U + U_W'(span_x <<< 2);
				cv_q    <= CENTER_V + V_W'(spanc_x <<< 2);
			end
			S_ZOOM: begin
				z_q <= zsh + D_W'(ZOOM_BASE);
			end
			S_DELTA: begin
				du_col_q <= D_W'(p_cz >>> 8);
				dv_row_q <= D_W'(p_cz >>> 8);
				dv_col_q <= D_W'(p_sz >>> 8);
				du_row_q <= D_W'(p_nsz >>> 8);
			end
			S_ORIGIN: begin
				u0_q <= cu_q - u_off_c - u_off_r;
				v0_q <= cv_q - v_off_c - v_off_r;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE:   if (req.start) state_q <= S_TRIG;
				S_TRIG:   state_q <= S_ZOOM;
				S_ZOOM:   state_q <= S_DELTA;
				S_DELTA:  state_q <= S_ORIGIN;
				S_ORIGIN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.busy = (state_q != S_IDLE) || done_q;
	assign rsp.done = done_q;
	assign rsp.geom = '{du_col: du_col_q, dv_col: dv_col_q, du_row: du_row_q,
		dv_row: dv_row_q, u0: u0_q, v0: v0_q};

endmodule

// ----- rtl/arztm_back.sv -----
// Rotozoom texture mapper back: texture store, (u,v) walker, keying and result register.
// Depends on arztm_pkg and arztm_out_if.
module arztm_back import arztm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  q_head_t      head,
	output logic         pop,
	output setup_req_t   req,
	input  setup_rsp_t   rsp,
	arztm_out_if.source  result
);

	logic [COLOR_W-1:0] tex_mem [TEX_W * TEX_H];
	logic [COLOR_W-1:0] texel_s1;

	// walker state
	logic [U_W-1:0]     u_acc_q, u_row_q;
	logic [V_W-1:0]     v_acc_q, v_row_q;
	logic signed [D_W-1:0] du_col_q, dv_col_q, du_row_q, dv_row_q;
	logic [X_W-1:0]     col_q;
	logic [Y_W-1:0]     row_q;

	// sample stage
	logic               valid_s1;
	logic [COLOR_W-1:0] bg_s1;
	logic [X_W-1:0]     x_s1;
	logic [Y_W-1:0]     y_s1;
	logic               last_s1;

	// result register
	logic               out_valid_q;
	logic [COLOR_W-1:0] colour_q;
	logic [X_W-1:0]     x_q;
	logic [Y_W-1:0]     y_q;
	logic               last_q;

	logic               out_free, s1_free;
	logic               do_texel, do_frame, do_pixel;
	logic               col_end;
	logic [ADDR_W-1:0]  rd_addr;
	logic [U_W-1:0]     u_row_nxt;
	logic [V_W-1:0]     v_row_nxt;

	assign out_free = !out_valid_q || result.ready;
	assign s1_free  = !valid_s1 || out_free;
	assign pop      = head.valid && !rsp.busy && s1_free;

	always_comb begin
		do_texel = 1'b0;
		do_frame = 1'b0;
		do_pixel = 1'b0;
		unique case (head.item.op)
			OP_TEXEL: do_texel = pop;
			OP_FRAME: do_frame = pop;
			OP_PIXEL: do_pixel = pop;
			default: ;
		endcase
	end

	assign req.start = do_frame;
	assign req.frame = head.item.frame;

	assign rd_addr   = {v_acc_q[V_W-1:8], u_acc_q[U_W-1:8]};
	assign col_end   = (col_q == X_W'(SCREEN_W - 1));
	assign u_row_nxt = u_row_q + U_W'(du_row_q);
	assign v_row_nxt = v_row_q + V_W'(dv_row_q);

	// texture store: one write or one registered read per cycle
	always_ff @(posedge clk) begin
		if (do_texel) begin
			tex_mem[head.item.addr] <= head.item.value;
		end
		if (do_pixel) begin
			texel_s1 <= tex_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (do_pixel) begin
			bg_s1   <= head.item.bg;
			x_s1    <= col_q;
			y_s1    <= row_q;
			last_s1 <= col_end && (row_q == Y_W'(SCREEN_H - 1));
		end
		if (valid_s1 && out_free) begin
			colour_q <= (texel_s1 != cfg.transparent_key) ? texel_s1 : bg_s1;
			x_q      <= x_s1;
			y_q      <= y_s1;
			last_q   <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_pixel) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_acc_q  <= '0;
			v_acc_q  <= '0;
			u_row_q  <= '0;
			v_row_q  <= '0;
			du_col_q <= '0;
			dv_col_q <= '0;
			du_row_q <= '0;
			dv_row_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (rsp.done) begin
			du_col_q <= rsp.geom.du_col;
			dv_col_q <= rsp.geom.dv_col;
			du_row_q <= rsp.geom.du_row;
			dv_row_q <= rsp.geom.dv_row;
			u_row_q  <= rsp.geom.u0;
			v_row_q  <= rsp.geom.v0;
			u_acc_q  <= rsp.geom.u0;
			v_acc_q  <= rsp.geom.v0;
			col_q    <= '0;
			row_q    <= '0;
		end else if (do_pixel) begin
			if (col_end) begin
				col_q   <= '0;
				row_q   <= (row_q == Y_W'(SCREEN_H - 1)) ? '0 : row_q + 1'b1;
				u_row_q <= u_row_nxt;
				v_row_q <= v_row_nxt;
				u_acc_q <= u_row_nxt;
				v_acc_q <= v_row_nxt;
			end else begin
				col_q   <= col_q + 1'b1;
				u_acc_q <= u_acc_q + U_W'(du_col_q);
				v_acc_q <= v_acc_q + V_W'(dv_col_q);
			end
		end
	end

	assign result.valid      = out_valid_q;
	assign result.colour     = colour_q;
	assign result.pixel_x    = x_q;
	assign result.pixel_y    = y_q;
	assign result.frame_last = last_q;

endmodule

// ----- rtl/affine_rotozoom_texture_mapper_core.sv -----
// Rotozoom texture mapper top level: config registers, front queue, setup and back end.
// Depends on arztm_pkg, arztm_if, arztm_front, arztm_setup, arztm_back.
//
//  channel   | dir | handshake     | word
//  ----------+-----+---------------+-------------------------------------------------
//  feed      | in  | valid / ready | kind, texel_address, texel_value, frame_number,
//            |     |               | background
//  result    | out | valid / ready | colour, pixel_x, pixel_y, frame_last
//  cfg       | in  | cfg_we        | cfg_index, cfg_data (write only)
//
// Pixel words sustain one per clock while result is ready and no frame setup runs; a pixel
// passes the queue, the texture read and the result register on its way to result. Texel
// writes land in the texture store as popped. A frame start holds the back end while the
// setup sequencer runs four multiply/add stages one after another, then loads the walker.
// Reset clears control and walker state; the texture store has no clearing pass, so it
// is ready at once after reset and holds nothing defined until written.
// A stalled result fills the sample stage and then the four-word queue, after which feed
// deasserts ready; configuration writes are always taken.
module affine_rotozoom_texture_mapper_core import arztm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	arztm_in_if.sink             feed,
	arztm_out_if.source          result
);

	cfg_t       cfg_q;
	q_head_t    head;
	logic       q_pop;
	setup_req_t req;
	setup_rsp_t rsp;

	// configuration registers; the user must write them only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.transparent_key  <= KEY_RST;
			cfg_q.rotation_step    <= ROT_RST;
			cfg_q.pan_step         <= PAN_RST;
			cfg_q.zoom_drift_shift <= DRIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY:   cfg_q.transparent_key  <= cfg_data;
				CFG_ROT:   cfg_q.rotation_step    <= cfg_data;
				CFG_PAN:   cfg_q.pan_step         <= cfg_data;
				CFG_DRIFT: cfg_q.zoom_drift_shift <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// front: accept and classify into the queue
	arztm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.head   (head),
		.pop    (q_pop)
	);

	// per-frame trig, zoom and origin
	arztm_setup u_setup (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.rsp    (rsp)
	);

	// back: texture store, walker, keying
	arztm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (q_pop),
		.req    (req),
		.rsp    (rsp),
		.result (result)
	);

`ifndef ASSERT_OFF
	// nothing leaves the queue while frame setup runs or the walker is being reloaded
	a_pop_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.busy |-> !q_pop)
		else $error("queue popped during frame setup");

	// a frame start reloads the walker once the sequencer has run its trig, zoom, delta and origin states
	a_setup_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && head.item.op == OP_FRAME) |-> ##5 rsp.done)
		else $error("frame setup did not finish in five cycles");

	// setup releases the back end right after the reload
	a_setup_release: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.busy)
		else $error("setup still busy after reload");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking bench for the rotozoom texture mapper core: a stimulus table, then random
// texel, frame and pixel words under random idle and stall, checked against a bench model.
// Depends on arztm_pkg, arztm_if and affine_rotozoom_texture_mapper_core.
module tb;
	import arztm_pkg::*;

	// kind 3 carries no operation; the core must drop it
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int IDLE_PCT      = 8;
	localparam int SETTLE_CYCLES = 40;    // frame setup and queue drain, with margin
	localparam int STALL_LIMIT   = 2000;  // cycles without any word moving
	localparam int REPORT_MAX    = 10;
	localparam int DRILL_N       = 25;

	typedef struct packed {
		logic [COLOR_W-1:0] colour;
		logic [X_W-1:0]     x;
		logic [Y_W-1:0]     y;
		logic               last;
	} pixel_t;

	// one stimulus row; want is only used where fixed is set
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] value;
		logic [FRAME_W-1:0] frame;
		logic [COLOR_W-1:0] bg;
		logic               fixed;
		pixel_t             want;
	} drill_t;

	// Directed rows. Before any frame start the deltas are zero, so every pixel samples
	// texel (0,0): those rows carry their result inline. After a frame start the model
	// predicts. Covers opaque/transparent at the reset key, the spare kind with all
	// fields at ones, frame numbers at the extremes and at each quarter turn.
	localparam drill_t DRILLS [DRILL_N] = '{
		'{KIND_TEXEL, 14'h0000, 8'h3C, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'hFF, 1'b1,
			'{8'h3C, 9'd0, 8'd0, 1'b0}},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'h00, 1'b1,
			'{8'h3C, 9'd1, 8'd0, 1'b0}},
		'{KIND_TEXEL, 14'h0000, 8'h0F, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'hA5, 1'b1,
			'{8'hA5, 9'd2, 8'd0, 1'b0}},
		'{KIND_TEXEL, 14'h3FFF, 8'hFF, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{KIND_SPARE, 14'h3FFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'h00, 1'b1,
			'{8'h00, 9'd3, 8'd0, 1'b0}},
		'{KIND_TEXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'hFF, 1'b1,
			'{8'h00, 9'd4, 8'd0, 1'b0}},
		'{KIND_FRAME, 14'h0000, 8'h00, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'h5A, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'hC3, 1'b0, '0},
		'{KIND_FRAME, 14'h0000, 8'h00, 32'hFFFF_FFFF, 8'h00, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'hFF, 1'b0, '0},
		'{KIND_FRAME, 14'h0000, 8'h00, 32'h8000_0000, 8'h00, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{KIND_FRAME, 14'h0000, 8'h00, 32'h0000_0040, 8'h00, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'h81, 1'b0, '0},
		'{KIND_FRAME, 14'h0000, 8'h00, 32'h0000_0080, 8'h00, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'h7E, 1'b0, '0},
		'{KIND_TEXEL, 14'h2AAA, 8'h55, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{KIND_TEXEL, 14'h1555, 8'hAA, 32'h0000_0000, 8'h00, 1'b0, '0},
		'{KIND_FRAME, 14'h0000, 8'h00, 32'h0000_00C0, 8'h00, 1'b0, '0},
		'{KIND_PIXEL, 14'h0000, 8'h00, 32'h0000_0000, 8'h0F, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	arztm_in_if  feed_if ();
	arztm_out_if result_if ();

	affine_rotozoom_texture_mapper_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.feed      (feed_if),
		.result    (result_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------
	// Bench model: register copies, texture shadow, walker state
	// ---------------------------------------------------------------------------------
	logic [COLOR_W-1:0] key_reg   = KEY_RST;
	logic [PHASE_W-1:0] rot_reg   = ROT_RST;
	logic [PHASE_W-1:0] pan_reg   = PAN_RST;
	logic [SHIFT_W-1:0] drift_reg = DRIFT_RST;

	// only entries the bench wrote are known; a pixel never lands on an unknown one
	logic [COLOR_W-1:0] tex_mem   [1 << ADDR_W];
	bit                 tex_known [1 << ADDR_W];

	logic [U_W-1:0] u_acc = '0;
	logic [U_W-1:0] u_row = '0;
	logic [V_W-1:0] v_acc = '0;
	logic [V_W-1:0] v_row = '0;
	int             du_col = 0;
	int             dv_col = 0;
	int             du_row = 0;
	int             dv_row = 0;
	int             col = 0;
	int             row = 0;

	pixel_t expected_pixels [$];
	int     mismatches = 0;
	int     stuck = 0;
	int     words_sent = 0;   // feed words accepted so far
	bit     quiet = 1'b0;   // no idling on either side while set

	// signed sine, 256 phases per turn, +-256 full scale
	function automatic int wave(input logic [31:0] phase);
		logic [7:0] i;
		logic [6:0] h;
		int         m;
		i = phase[7:0];
		h = i[6:0];
		m = (h <= 7'd64) ? int'(QUARTER_SINE[h]) : int'(QUARTER_SINE[128 - int'(h)]);
		return i[7] ? -m : m;
	endfunction

	// frame start: deltas from angle and zoom, walker seeded at screen (0,0)
	task automatic plan_frame(input logic [FRAME_W-1:0] f);
		logic [31:0] ang;
		logic [31:0] zph;
		logic [31:0] pan;
		int          cos_a;
		int          sin_a;
		int          zoom;
		int          cu;
		int          cv;
		int          ur;
		int          vr;
		ang   = f * {24'd0, rot_reg};
		cos_a = wave(ang + 32'd64);
		sin_a = wave(ang);
		zph   = f + (f >> drift_reg);
		// >>> on int floors negative products, as the hardware shift does
		zoom  = ZOOM_BASE + ((ZOOM_AMP * wave(zph)) >>> 8);
		pan   = f * {24'd0, pan_reg};
		cu    = (TEX_W / 2) * 256 + wave(pan) * 4;
		cv    = (TEX_H / 2) * 256 + wave(pan + 32'd64) * 4;
		du_col = (cos_a * zoom) >>> 8;
		du_row = (-sin_a * zoom) >>> 8;
		dv_col = (sin_a * zoom) >>> 8;
		dv_row = (cos_a * zoom) >>> 8;
		ur = cu - HALF_W * du_col - HALF_H * du_row;
		vr = cv - HALF_W * dv_col - HALF_H * dv_row;
		u_row = U_W'(ur);
		v_row = V_W'(vr);
		u_acc = u_row;
		v_acc = v_row;
		col   = 0;
		row   = 0;
	endtask

	function automatic logic [COLOR_W-1:0] pick_colour();
		return ($urandom_range(3) == 0) ? key_reg : COLOR_W'($urandom);
	endfunction

	// ---------------------------------------------------------------------------------
	// Feed side
	// ---------------------------------------------------------------------------------
	task automatic send_word(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
		input logic [COLOR_W-1:0] value, input logic [FRAME_W-1:0] frame,
		input logic [COLOR_W-1:0] bg);
		if (!quiet) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				feed_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		feed_if.valid         <= 1'b1;
		feed_if.kind          <= kind;
		feed_if.texel_address <= addr;
		feed_if.texel_value   <= value;
		feed_if.frame_number  <= frame;
		feed_if.background    <= bg;
		@(posedge clk);
		while (!feed_if.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic write_texel(input logic [ADDR_W-1:0] addr, input logic [COLOR_W-1:0] value);
		tex_mem[addr]   = value;
		tex_known[addr] = 1'b1;
		send_word(KIND_TEXEL, addr, value, $urandom, COLOR_W'($urandom));
	endtask

	task automatic start_frame_word(input logic [FRAME_W-1:0] f);
		plan_frame(f);
		send_word(KIND_FRAME, ADDR_W'($urandom), COLOR_W'($urandom), f, COLOR_W'($urandom));
	endtask

	// Predicts one pixel and steps the walker. A texel the walker is about to hit that
	// was never written gets a write first.
	task automatic pixel_word(input logic [COLOR_W-1:0] bg, input logic fixed, input pixel_t want);
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] texel;
		pixel_t             pred;
		addr = {v_acc[V_W-1:8], u_acc[U_W-1:8]};
		if (!tex_known[addr])
			write_texel(addr, pick_colour());
		texel       = tex_mem[addr];
		pred.colour = (texel != key_reg) ? texel : bg;
		pred.x      = X_W'(col);
		pred.y      = Y_W'(row);
		pred.last   = (col == SCREEN_W - 1) && (row == SCREEN_H - 1);
		col++;
		if (col >= SCREEN_W) begin
			// end of row: past the last row the count wraps, the row start keeps stepping
			col = 0;
			row++;
			if (row >= SCREEN_H)
				row = 0;
			u_row = u_row + U_W'(du_row);
			v_row = v_row + V_W'(dv_row);
			u_acc = u_row;
			v_acc = v_row;
		end else begin
			u_acc = u_acc + U_W'(du_col);
			v_acc = v_acc + V_W'(dv_col);
		end
		expected_pixels.push_back(fixed ? want : pred);
		send_word(KIND_PIXEL, ADDR_W'($urandom), COLOR_W'($urandom), $urandom, bg);
	endtask

	// Stop feeding until every result is back, then let setup work finish.
	task automatic wait_drained();
		feed_if.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic [COLOR_W-1:0] key, input logic [PHASE_W-1:0] rot,
		input logic [PHASE_W-1:0] pan, input logic [SHIFT_W-1:0] drift);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_KEY;
		cfg_data  <= key;
		@(posedge clk);
		cfg_index <= CFG_ROT;
		cfg_data  <= rot;
		@(posedge clk);
		cfg_index <= CFG_PAN;
		cfg_data  <= pan;
		@(posedge clk);
		// upper data bits are junk here; only the low five land in the register
		cfg_index <= CFG_DRIFT;
		cfg_data  <= {3'($urandom), drift};
		@(posedge clk);
		cfg_we    <= 1'b0;
		key_reg   = key;
		rot_reg   = rot;
		pan_reg   = pan;
		drift_reg = drift;
	endtask

	// Mostly frames followed by pixel bursts, some long enough to cross rows;
	// texel rewrites, spare-kind noise and the odd full drain mixed in.
	// count is in feed words of any kind.
	task automatic run_mix(input int count);
		int          base;
		int          pick;
		int          burst;
		logic [31:0] f;
		base = words_sent;
		while (words_sent - base < count) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				f = ($urandom_range(1) == 1) ? $urandom : $urandom_range(1023);
				start_frame_word(f);
			end else if (pick < 16) begin
				write_texel(ADDR_W'($urandom), pick_colour());
			end else if (pick < 19) begin
				send_word(KIND_SPARE, ADDR_W'($urandom), COLOR_W'($urandom), $urandom,
					COLOR_W'($urandom));
			end else if (pick < 20) begin
				wait_drained();
			end else begin
				burst = ($urandom_range(15) == 0) ? $urandom_range(700, 320) : $urandom_range(40, 1);
				repeat (burst)
					if (words_sent - base < count)
						pixel_word(COLOR_W'($urandom), 1'b0, '0);
			end
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Result side: random stall, compare against the oldest expectation
	// ---------------------------------------------------------------------------------
	always @(posedge clk)
		result_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : check_results
		pixel_t got;
		pixel_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			got = '{result_if.colour, result_if.pixel_x, result_if.pixel_y, result_if.frame_last};
			if (expected_pixels.size() == 0) begin
				note_mismatch($sformatf("unexpected word colour %0d x %0d y %0d last %0d",
					got.colour, got.x, got.y, got.last));
			end else begin
				want = expected_pixels.pop_front();
				if (got.colour !== want.colour || got.x !== want.x ||
					got.y !== want.y || got.last !== want.last)
					note_mismatch($sformatf(
						"want colour %0d x %0d y %0d last %0d, got colour %0d x %0d y %0d last %0d",
						want.colour, want.x, want.y, want.last,
						got.colour, got.x, got.y, got.last));
			end
		end
	end

	// no word moved on either side for too long: hang
	always @(posedge clk) begin
		if (!arst_n || (feed_if.valid && feed_if.ready) || (result_if.valid && result_if.ready)) begin
			stuck <= 0;
		end else if (stuck >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d results pending",
				stuck, expected_pixels.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			stuck <= stuck + 1;
		end
	end

	// ---------------------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------------------
	initial begin
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_index             = CFG_KEY;
		cfg_data              = '0;
		feed_if.valid         = 1'b0;
		feed_if.kind          = KIND_TEXEL;
		feed_if.texel_address = '0;
		feed_if.texel_value   = '0;
		feed_if.frame_number  = '0;
		feed_if.background    = '0;
		result_if.ready       = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows at reset register values
		for (int i = 0; i < DRILL_N; i++) begin
			case (DRILLS[i].kind)
				KIND_TEXEL: write_texel(DRILLS[i].addr, DRILLS[i].value);
				KIND_FRAME: start_frame_word(DRILLS[i].frame);
				KIND_PIXEL: pixel_word(DRILLS[i].bg, DRILLS[i].fixed, DRILLS[i].want);
				default: send_word(DRILLS[i].kind, DRILLS[i].addr, DRILLS[i].value,
					DRILLS[i].frame, DRILLS[i].bg);
			endcase
		end
		run_mix(300);

		// register extremes; the top one also runs with both sides never idling
		set_regs(8'd0, 8'd0, 8'd0, 5'd0);
		run_mix(300);
		set_regs(8'hFF, 8'hFF, 8'hFF, 5'd31);
		quiet = 1'b1;
		run_mix(300);
		quiet = 1'b0;

		repeat (3) begin
			set_regs(COLOR_W'($urandom), PHASE_W'($urandom), PHASE_W'($urandom),
				SHIFT_W'($urandom));
			run_mix(330);
		end

		wait_drained();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
